FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, off while rst_n is low.
`define T2C_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ticks_to_calendar_date: assertion failed");

// Overlapping implication form.
`define T2C_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `T2C_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

FILE: rtl/t2c_pkg.sv
`default_nettype none

package t2c_pkg;

  localparam logic [62:0] TICKS_LAST = 63'd2650467743999999999;

  localparam int unsigned SEC_STAGES = 11;
  localparam int unsigned DAY_STAGES = 8;
  localparam int unsigned CAL_STAGES = 5;
  localparam int unsigned NUM_STAGES = SEC_STAGES + DAY_STAGES + CAL_STAGES;

  typedef struct packed {
    logic [37:0] secs;
    logic [23:0] frac;
    logic        oor;
  } sec_res_t;

  typedef struct packed {
    logic [21:0] days;
    logic [16:0] tod;
    logic [23:0] frac;
    logic        oor;
  } day_res_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [8:0]  yday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [23:0] frac;
    logic [2:0]  wday;
    logic        leap;
    logic        oor;
  } date_t;

endpackage

`default_nettype wire

FILE: rtl/t2c_ctrl.sv
`default_nettype none

module t2c_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             out_ready_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  output logic [t2c_pkg::NUM_STAGES-1:0]   en_o
);

  logic [t2c_pkg::NUM_STAGES-1:0] valid_q, valid_d;
  logic [t2c_pkg::NUM_STAGES:0]   rdy;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    rdy[t2c_pkg::NUM_STAGES] = out_ready_i;
    for (int k = t2c_pkg::NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < t2c_pkg::NUM_STAGES; k++) begin
      valid_d[k] = rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en_o        = rdy[t2c_pkg::NUM_STAGES-1:0];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[t2c_pkg::NUM_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/t2c_sec_div.sv
`default_nettype none

// ticks / 10^7 as (ticks >> 7) / 78125, five quotient bits per stage.
module t2c_sec_div (
  input  logic                             clk_i,
  input  logic [t2c_pkg::SEC_STAGES-1:0]   en_i,
  input  logic [62:0]                      tick_count_i,
  output t2c_pkg::sec_res_t                res_o
);

  localparam logic [17:0] DIVISOR = 18'd78125;
  localparam int unsigned LAST    = t2c_pkg::SEC_STAGES - 1;

  function automatic logic [21:0] div_chunk(input logic [16:0] rem, input logic [4:0] bits);
    logic [17:0] r;
    logic [4:0]  q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 4; i >= 0; i--) begin
      r = {r[16:0], bits[i]};
      if (r >= DIVISOR) begin
        r    = r - DIVISOR;
        q[i] = 1'b1;
      end
    end
    return {r[16:0], q};
  endfunction

  logic [54:0] num_q [t2c_pkg::SEC_STAGES];
  logic [54:0] num_d [t2c_pkg::SEC_STAGES];
  logic [16:0] rem_q [t2c_pkg::SEC_STAGES];
  logic [16:0] rem_d [t2c_pkg::SEC_STAGES];
  logic [6:0]  lo_q  [t2c_pkg::SEC_STAGES];
  logic        oor_q [t2c_pkg::SEC_STAGES];

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  always_comb begin
    logic [21:0] step;
    step     = div_chunk(17'd0, tick_count_i[61:57]);
    num_d[0] = {tick_count_i[56:7], step[4:0]};
    rem_d[0] = step[21:5];
    for (int k = 1; k < t2c_pkg::SEC_STAGES; k++) begin
      step     = div_chunk(rem_q[k-1], num_q[k-1][54:50]);
      num_d[k] = {num_q[k-1][49:0], step[4:0]};
      rem_d[k] = step[21:5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num_q[0] <= num_d[0];
      rem_q[0] <= rem_d[0];
      lo_q[0]  <= tick_count_i[6:0];
      oor_q[0] <= tick_count_i > t2c_pkg::TICKS_LAST;
    end
    for (int k = 1; k < t2c_pkg::SEC_STAGES; k++) begin
      if (en_i[k]) begin
        num_q[k] <= num_d[k];
        rem_q[k] <= rem_d[k];
        lo_q[k]  <= lo_q[k-1];
        oor_q[k] <= oor_q[k-1];
      end
    end
  end

  assign res_o.secs = num_q[LAST][37:0];
  assign res_o.frac = {rem_q[LAST], lo_q[LAST]};
  assign res_o.oor  = oor_q[LAST];

endmodule

`default_nettype wire

FILE: rtl/t2c_day_div.sv
`default_nettype none

// secs / 86400 as (secs >> 7) / 675, four quotient bits per stage.
module t2c_day_div (
  input  logic                             clk_i,
  input  logic [t2c_pkg::DAY_STAGES-1:0]   en_i,
  input  t2c_pkg::sec_res_t                sec_i,
  output t2c_pkg::day_res_t                res_o
);

  localparam logic [10:0] DIVISOR = 11'd675;
  localparam int unsigned LAST    = t2c_pkg::DAY_STAGES - 1;

  function automatic logic [13:0] div_chunk(input logic [9:0] rem, input logic [3:0] bits);
    logic [10:0] r;
    logic [3:0]  q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      r = {r[9:0], bits[i]};
      if (r >= DIVISOR) begin
        r    = r - DIVISOR;
        q[i] = 1'b1;
      end
    end
    return {r[9:0], q};
  endfunction

  logic [31:0] num_q  [t2c_pkg::DAY_STAGES];
  logic [31:0] num_d  [t2c_pkg::DAY_STAGES];
  logic [9:0]  rem_q  [t2c_pkg::DAY_STAGES];
  logic [9:0]  rem_d  [t2c_pkg::DAY_STAGES];
  logic [6:0]  lo_q   [t2c_pkg::DAY_STAGES];
  logic [23:0] frac_q [t2c_pkg::DAY_STAGES];
  logic        oor_q  [t2c_pkg::DAY_STAGES];

  always_comb begin
    logic [31:0] src;
    logic [13:0] step;
    src      = {1'b0, sec_i.secs[37:7]};
    step     = div_chunk(10'd0, src[31:28]);
    num_d[0] = {src[27:0], step[3:0]};
    rem_d[0] = step[13:4];
    for (int k = 1; k < t2c_pkg::DAY_STAGES; k++) begin
      step     = div_chunk(rem_q[k-1], num_q[k-1][31:28]);
      num_d[k] = {num_q[k-1][27:0], step[3:0]};
      rem_d[k] = step[13:4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num_q[0]  <= num_d[0];
      rem_q[0]  <= rem_d[0];
      lo_q[0]   <= sec_i.secs[6:0];
      frac_q[0] <= sec_i.frac;
      oor_q[0]  <= sec_i.oor;
    end
    for (int k = 1; k < t2c_pkg::DAY_STAGES; k++) begin
      if (en_i[k]) begin
        num_q[k]  <= num_d[k];
        rem_q[k]  <= rem_d[k];
        lo_q[k]   <= lo_q[k-1];
        frac_q[k] <= frac_q[k-1];
        oor_q[k]  <= oor_q[k-1];
      end
    end
  end

  assign res_o.days = num_q[LAST][21:0];
  assign res_o.tod  = {rem_q[LAST], lo_q[LAST]};
  assign res_o.frac = frac_q[LAST];
  assign res_o.oor  = oor_q[LAST];

endmodule

`default_nettype wire

FILE: rtl/t2c_cal.sv
`default_nettype none

// Year periods, time of day, weekday and month lookup.
module t2c_cal (
  input  logic                             clk_i,
  input  logic [t2c_pkg::CAL_STAGES-1:0]   en_i,
  input  t2c_pkg::day_res_t                day_i,
  output t2c_pkg::date_t                   date_o
);

  localparam logic [21:0] D400 = 22'd146097;
  localparam logic [17:0] D100 = 18'd36524;
  localparam logic [15:0] D4   = 16'd1461;
  localparam logic [10:0] D1   = 11'd365;
  localparam logic [16:0] DHR  = 17'd3600;
  localparam logic [11:0] DMIN = 12'd60;

  localparam logic [8:0] START_COMMON [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] START_LEAP [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  // 8 == 1 mod 7: fold octal digits.
  function automatic logic [2:0] mod7(input logic [23:0] x);
    logic [5:0] s;
    logic [3:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(x[3*i +: 3]);
    end
    t = 4'(s[5:3]) + 4'(s[2:0]);
    if (t >= 4'd14) begin
      t = t - 4'd14;
    end else if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[2:0];
  endfunction

  typedef struct packed {
    logic [4:0]  n400;
    logic [17:0] r400;
    logic [16:0] tod;
    logic [23:0] frac;
    logic [2:0]  wday;
    logic        oor;
  } st_a_t;

  typedef struct packed {
    logic [4:0]  n400;
    logic [1:0]  n100;
    logic [15:0] r100;
    logic [4:0]  hour;
    logic [11:0] rhr;
    logic [23:0] frac;
    logic [2:0]  wday;
    logic        oor;
  } st_b_t;

  typedef struct packed {
    logic [4:0]  n400;
    logic [1:0]  n100;
    logic [4:0]  n4;
    logic [10:0] r4;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [23:0] frac;
    logic [2:0]  wday;
    logic        oor;
  } st_c_t;

  typedef struct packed {
    logic [13:0] year;
    logic [8:0]  yday;
    logic        leap;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [23:0] frac;
    logic [2:0]  wday;
    logic        oor;
  } st_d_t;

  st_a_t          a_q, a_d;
  st_b_t          b_q, b_d;
  st_c_t          c_q, c_d;
  st_d_t          d_q, d_d;
  t2c_pkg::date_t e_q, e_d;

  // 400-year periods, weekday.
  always_comb begin
    logic [21:0] r;
    r        = day_i.days;
    a_d.n400 = '0;
    for (int k = 4; k >= 0; k--) begin
      if (r >= (D400 << k)) begin
        r           = r - (D400 << k);
        a_d.n400[k] = 1'b1;
      end
    end
    a_d.r400 = r[17:0];
    a_d.tod  = day_i.tod;
    a_d.frac = day_i.frac;
    a_d.wday = mod7(24'(day_i.days) + 24'd1);
    a_d.oor  = day_i.oor;
  end

  // 100-year periods capped at 3, hour.
  always_comb begin
    logic [16:0] t;
    logic [17:0] sub;
    if (a_q.r400 >= 18'(3 * D100)) begin
      b_d.n100 = 2'd3;
      sub      = 18'(3 * D100);
    end else if (a_q.r400 >= 18'(2 * D100)) begin
      b_d.n100 = 2'd2;
      sub      = 18'(2 * D100);
    end else if (a_q.r400 >= D100) begin
      b_d.n100 = 2'd1;
      sub      = D100;
    end else begin
      b_d.n100 = 2'd0;
      sub      = '0;
    end
    b_d.r100 = 16'(a_q.r400 - sub);
    t        = a_q.tod;
    b_d.hour = '0;
    for (int k = 4; k >= 0; k--) begin
      if (t >= (DHR << k)) begin
        t           = t - (DHR << k);
        b_d.hour[k] = 1'b1;
      end
    end
    b_d.rhr  = t[11:0];
    b_d.n400 = a_q.n400;
    b_d.frac = a_q.frac;
    b_d.wday = a_q.wday;
    b_d.oor  = a_q.oor;
  end

  // 4-year periods, minute and second.
  always_comb begin
    logic [15:0] r;
    logic [11:0] t;
    r      = b_q.r100;
    c_d.n4 = '0;
    for (int k = 4; k >= 0; k--) begin
      if (r >= (D4 << k)) begin
        r         = r - (D4 << k);
        c_d.n4[k] = 1'b1;
      end
    end
    c_d.r4     = r[10:0];
    t          = b_q.rhr;
    c_d.minute = '0;
    for (int k = 5; k >= 0; k--) begin
      if (t >= (DMIN << k)) begin
        t             = t - (DMIN << k);
        c_d.minute[k] = 1'b1;
      end
    end
    c_d.second = t[5:0];
    c_d.n400   = b_q.n400;
    c_d.n100   = b_q.n100;
    c_d.hour   = b_q.hour;
    c_d.frac   = b_q.frac;
    c_d.wday   = b_q.wday;
    c_d.oor    = b_q.oor;
  end

  // Single years capped at 3, year number, leap flag.
  always_comb begin
    logic [1:0]  n1;
    logic [10:0] sub;
    if (c_q.r4 >= 11'(3 * D1)) begin
      n1  = 2'd3;
      sub = 11'(3 * D1);
    end else if (c_q.r4 >= 11'(2 * D1)) begin
      n1  = 2'd2;
      sub = 11'(2 * D1);
    end else if (c_q.r4 >= D1) begin
      n1  = 2'd1;
      sub = D1;
    end else begin
      n1  = 2'd0;
      sub = '0;
    end
    d_d.yday   = 9'(c_q.r4 - sub);
    d_d.year   = 14'd1601 + 14'(c_q.n400) * 14'd400 + 14'(c_q.n100) * 14'd100
               + 14'({c_q.n4, 2'b00}) + 14'(n1);
    d_d.leap   = (n1 == 2'd3) && ((c_q.n4 != 5'd24) || (c_q.n100 == 2'd3));
    d_d.hour   = c_q.hour;
    d_d.minute = c_q.minute;
    d_d.second = c_q.second;
    d_d.frac   = c_q.frac;
    d_d.wday   = c_q.wday;
    d_d.oor    = c_q.oor;
  end

  // Month lookup, out-of-range zeroing.
  always_comb begin
    logic [3:0] m;
    logic [8:0] start;
    m = '0;
    for (int i = 1; i < 12; i++) begin
      if (d_q.yday >= (d_q.leap ? START_LEAP[i] : START_COMMON[i])) begin
        m = m + 4'd1;
      end
    end
    start = d_q.leap ? START_LEAP[m] : START_COMMON[m];
    e_d   = '0;
    if (d_q.oor) begin
      e_d.oor = 1'b1;
    end else begin
      e_d.year   = d_q.year;
      e_d.month  = m + 4'd1;
      e_d.mday   = 5'(d_q.yday - start + 9'd1);
      e_d.yday   = d_q.yday;
      e_d.hour   = d_q.hour;
      e_d.minute = d_q.minute;
      e_d.second = d_q.second;
      e_d.frac   = d_q.frac;
      e_d.wday   = d_q.wday;
      e_d.leap   = d_q.leap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q <= a_d;
    end
    if (en_i[1]) begin
      b_q <= b_d;
    end
    if (en_i[2]) begin
      c_q <= c_d;
    end
    if (en_i[3]) begin
      d_q <= d_d;
    end
    if (en_i[4]) begin
      e_q <= e_d;
    end
  end

  assign date_o = e_q;

endmodule

`default_nettype wire

FILE: rtl/ticks_to_calendar_date.sv
// Converts a count of 100 ns ticks since 1601-01-01 00:00:00 UTC into a
// Gregorian date, time of day, weekday (0 = Sunday) and leap-year flag.
// Input channel: tick_count_i with in_valid_i / in_ready_o. Output channel:
// all result fields with out_valid_o / out_ready_i. A transaction happens on
// a rising edge where valid and ready are both high. A count past the end of
// year 9999 returns out_of_range_o = 1 with every other field zero.
// Depth: 24 register stages, set by the divide by 10^7 (11 stages,
// 5 quotient bits each), the divide by 86400 (8 stages, 4 bits each)
// and 5 calendar stages. Throughput: one transaction per cycle while
// in_ready_o is high.
// Each stage carries its own valid bit; empty stages fill while the output
// is stalled, so in_ready_o only falls once all 24 stages hold transactions
// and out_ready_i is low. Nothing is dropped or repeated under stall.
// Reset (rst_ni low, asynchronous) empties the pipeline; no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module ticks_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [62:0] tick_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [8:0]  day_of_year_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o,
  output logic [23:0] fraction_ticks_o,
  output logic [2:0]  weekday_o,
  output logic        leap_year_o,
  output logic        out_of_range_o
);

  localparam int unsigned DAY_LO = t2c_pkg::SEC_STAGES;
  localparam int unsigned CAL_LO = t2c_pkg::SEC_STAGES + t2c_pkg::DAY_STAGES;

  logic [t2c_pkg::NUM_STAGES-1:0] en;
  t2c_pkg::sec_res_t              sec_res;
  t2c_pkg::day_res_t              day_res;
  t2c_pkg::date_t                 date;

  t2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .en_o        (en)
  );

  t2c_sec_div u_sec_div (
    .clk_i        (clk_i),
    .en_i         (en[DAY_LO-1:0]),
    .tick_count_i (tick_count_i),
    .res_o        (sec_res)
  );

  t2c_day_div u_day_div (
    .clk_i (clk_i),
    .en_i  (en[CAL_LO-1:DAY_LO]),
    .sec_i (sec_res),
    .res_o (day_res)
  );

  t2c_cal u_cal (
    .clk_i  (clk_i),
    .en_i   (en[t2c_pkg::NUM_STAGES-1:CAL_LO]),
    .day_i  (day_res),
    .date_o (date)
  );

  assign year_o             = date.year;
  assign month_o            = date.month;
  assign day_of_month_o     = date.mday;
  assign day_of_year_o      = date.yday;
  assign hour_of_day_o      = date.hour;
  assign minute_of_hour_o   = date.minute;
  assign second_of_minute_o = date.second;
  assign fraction_ticks_o   = date.frac;
  assign weekday_o          = date.wday;
  assign leap_year_o        = date.leap;
  assign out_of_range_o     = date.oor;

  logic fields_zero;
  logic date_legal;

  assign fields_zero = (year_o == '0) && (month_o == '0) && (day_of_month_o == '0)
                    && (day_of_year_o == '0) && (hour_of_day_o == '0)
                    && (minute_of_hour_o == '0) && (second_of_minute_o == '0)
                    && (fraction_ticks_o == '0) && (weekday_o == '0) && !leap_year_o;

  assign date_legal = (year_o >= 14'd1601) && (year_o <= 14'd9999)
                   && (month_o >= 4'd1) && (month_o <= 4'd12)
                   && (day_of_month_o >= 5'd1) && (hour_of_day_o <= 5'd23)
                   && (minute_of_hour_o <= 6'd59) && (second_of_minute_o <= 6'd59)
                   && (fraction_ticks_o <= 24'd9999999) && (weekday_o <= 3'd6)
                   && (day_of_year_o <= 9'd365);

  `T2C_ASSERT_IMP(a_oor_zero, clk_i, rst_ni, out_valid_o && out_of_range_o, fields_zero)
  `T2C_ASSERT_IMP(a_date_legal, clk_i, rst_ni, out_valid_o && !out_of_range_o, date_legal)
  `T2C_ASSERT_IMP(a_full_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

`default_nettype wire
